// File: rtl/core/auth_flood_window_detector_defines.svh
// assertion macros for the auth flood window detector
// no dependencies; included by files that carry concurrent checks
`ifndef AUTH_FLOOD_WINDOW_DETECTOR_DEFINES_SVH
`define AUTH_FLOOD_WINDOW_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define AFWD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afwd same-cycle check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define AFWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afwd next-cycle check failed");

`endif

// File: rtl/core/afwd_pkg.sv
// shared types and constants of the auth flood window detector
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps

package afwd_pkg;

  localparam int ADDR_W     = 48;
  localparam int TIME_W     = 32;
  localparam int WIN_W      = 16;
  localparam int THR_W      = 10;
  localparam int OP_W       = 2;
  localparam int COUNT_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // item opcodes; the fourth code is ignored
  typedef enum logic [OP_W-1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } afwd_op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_THRESHOLD = 2'd1
  } afwd_cfg_idx_t;

  // one ring slot
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
  } afwd_slot_t;

  // ring write command from the controller
  typedef struct packed {
    logic              rec;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
  } afwd_wr_t;

  // one lane of the cell row: an address with its valid
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } afwd_lane_t;

endpackage

// File: rtl/core/afwd_if.sv
// channel interfaces of the auth flood window detector
// depends on afwd_pkg for field widths
`timescale 1ns / 1ps

// event / query / clear items
interface afwd_item_if import afwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] station_address;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, output op, output station_address, output now_time,
                  input ready);
  modport sink   (input valid, input op, input station_address, input now_time,
                  output ready);
endinterface

// query results
interface afwd_result_if import afwd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] best_count;
  logic [ADDR_W-1:0]  best_address;

  modport source (output valid, output best_count, output best_address, input ready);
  modport sink   (input valid, input best_count, input best_address, output ready);
endinterface

// configuration register writes
interface afwd_cfg_if import afwd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/afwd_ring.sv
// slot memory of the event ring, write pointer, fill count and window test
// depends on afwd_pkg; streams in-window addresses to the cell row
`timescale 1ns / 1ps

module afwd_ring import afwd_pkg::*; #(
  parameter int RING_DEPTH = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  afwd_wr_t                      wr,
  input  logic                          rd_en,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_idx,
  input  logic [TIME_W-1:0]             query_time,
  input  logic [WIN_W-1:0]              window,
  output afwd_lane_t                    item
);

  localparam int IdxW  = $clog2(RING_DEPTH);
  localparam int FillW = $clog2(RING_DEPTH + 1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(RING_DEPTH - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(RING_DEPTH);

  afwd_slot_t mem [RING_DEPTH];

  logic [IdxW-1:0]   wp;
  logic [FillW-1:0]  fill;
  logic              rd_valid;
  logic [IdxW-1:0]   rd_idx_q;
  afwd_slot_t        rd_slot;
  logic signed [TIME_W:0] age;
  logic              live;

  // slot writes
  always_ff @(posedge clk) begin
    if (wr.rec) begin
      mem[wp] <= '{addr: wr.addr, stamp: wr.stamp};
    end
  end

  // registered slot read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot <= mem[rd_idx];
    end
  end

  // write pointer and fill count; entries at or above fill read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (wr.clr) begin
      wp   <= '0;
      fill <= '0;
    end else if (wr.rec) begin
      wp   <= (wp == LastIdx) ? '0 : wp + 1'b1;
      fill <= (fill == FullFill) ? fill : fill + 1'b1;
    end
  end

  // window test on the slot just read
  assign age  = $signed({1'b0, query_time}) - $signed({1'b0, rd_slot.stamp});
  assign live = rd_valid && (FillW'(rd_idx_q) < fill) && (rd_slot.stamp != '0) &&
                (age <= $signed({{(TIME_W + 1 - WIN_W){1'b0}}, window}));

  // read pipeline and outgoing lane
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      item.valid <= 1'b0;
    end else begin
      rd_valid   <= rd_en;
      rd_idx_q   <= rd_idx;
      item.valid <= live;
      item.addr  <= rd_slot.addr;
    end
  end

endmodule

// File: rtl/core/afwd_cell.sv
// one counting cell: claims the first new address it sees and counts repeats
// depends on afwd_pkg; also forwards the best-so-far token to its neighbor
`timescale 1ns / 1ps

module afwd_cell import afwd_pkg::*; #(
  parameter int CNT_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             flush,
  input  afwd_lane_t       item_in,
  input  afwd_lane_t       tok_in,
  input  logic [CNT_W-1:0] tok_cnt_in,
  output afwd_lane_t       item_out,
  output afwd_lane_t       tok_out,
  output logic [CNT_W-1:0] tok_cnt_out
);

  logic              used;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  count;
  logic              hit;
  logic              take;

  assign hit  = used && (addr == item_in.addr);
  // strict compare keeps the earlier cell, i.e. the earlier first occurrence
  assign take = used && (count > tok_cnt_in);

  // claim, count, and pass on what is not ours
  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= 1'b0;
      item_out.valid <= 1'b0;
      tok_out.valid  <= 1'b0;
    end else begin
      if (flush) begin
        used <= 1'b0;
      end else if (item_in.valid) begin
        if (!used) begin
          used  <= 1'b1;
          addr  <= item_in.addr;
          count <= CNT_W'(1);
        end else if (hit) begin
          count <= count + 1'b1;
        end
      end
      item_out.valid <= item_in.valid && used && !hit;
      item_out.addr  <= item_in.addr;
      tok_out.valid  <= tok_in.valid;
      tok_out.addr   <= take ? addr : tok_in.addr;
      tok_cnt_out    <= take ? count : tok_cnt_in;
    end
  end

endmodule

// File: rtl/core/afwd_chain.sv
// row of counting cells, one per ring slot, linked item lane and token lane
// depends on afwd_pkg and afwd_cell
`timescale 1ns / 1ps

module afwd_chain import afwd_pkg::*; #(
  parameter int RING_DEPTH = 512
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               flush,
  input  afwd_lane_t                         item_in,
  input  afwd_lane_t                         tok_in,
  input  logic [$clog2(RING_DEPTH+1)-1:0]    tok_cnt_in,
  output afwd_lane_t                         item_out,
  output afwd_lane_t                         tok_out,
  output logic [$clog2(RING_DEPTH+1)-1:0]    tok_cnt_out
);

  localparam int CntW = $clog2(RING_DEPTH + 1);

  afwd_lane_t      item_w [RING_DEPTH + 1];
  afwd_lane_t      tok_w  [RING_DEPTH + 1];
  logic [CntW-1:0] cnt_w  [RING_DEPTH + 1];

  assign item_w[0] = item_in;
  assign tok_w[0]  = tok_in;
  assign cnt_w[0]  = tok_cnt_in;

  // cells in slot order
  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
    afwd_cell #(
      .CNT_W (CntW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .flush       (flush),
      .item_in     (item_w[k]),
      .tok_in      (tok_w[k]),
      .tok_cnt_in  (cnt_w[k]),
      .item_out    (item_w[k+1]),
      .tok_out     (tok_w[k+1]),
      .tok_cnt_out (cnt_w[k+1])
    );
  end

  assign item_out    = item_w[RING_DEPTH];
  assign tok_out     = tok_w[RING_DEPTH];
  assign tok_cnt_out = cnt_w[RING_DEPTH];

endmodule

// File: rtl/core/auth_flood_window_detector.sv
// Record and clear items are applied when accepted; a query result becomes valid once
// the slot memory is swept one read per cycle and then the best-so-far token crosses the
// RING_DEPTH-cell row one cell per cycle. One query is in flight at a
// time; records and clears are taken in any idle cycle, also while a result waits.
// Reset is synchronous: the ring reads empty at once (fill count), no clearing pass;
// window_seconds resets to 10 and flood_threshold to 20.
`timescale 1ns / 1ps
`include "auth_flood_window_detector_defines.svh"

module auth_flood_window_detector import afwd_pkg::*; #(
  parameter int RING_DEPTH = 512
) (
  input logic           clk,
  input logic           rst,
  afwd_item_if.sink     item,
  afwd_result_if.source result,
  afwd_cfg_if.sink      cfg
);

  localparam int IdxW = $clog2(RING_DEPTH);
  localparam int CntW = $clog2(RING_DEPTH + 1);
  localparam int CmpW = (CntW > THR_W) ? CntW : THR_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_WAIT
  } state_t;

  state_t            state;
  logic [IdxW-1:0]   rd_idx;
  logic [TIME_W-1:0] query_time;
  logic              last_d1;
  logic              last_d2;
  logic              tok_launch;
  logic [CntW-1:0]   res_count;
  logic [ADDR_W-1:0] res_addr;
  logic [WIN_W-1:0]  window_seconds;
  logic [THR_W-1:0]  flood_threshold;

  logic              accept;
  logic              query_go;
  afwd_wr_t          wr;
  afwd_lane_t        ring_item;
  afwd_lane_t        tok_in;
  afwd_lane_t        chain_item_out;
  afwd_lane_t        tok_out;
  logic [CntW-1:0]   tok_cnt_out;
  logic              qualify;
  logic [CmpW-1:0]   res_wide;
  logic [COUNT_W-1:0] res_sat;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;

  // opcode decode of an accepted transaction
  always_comb begin
    wr       = '{rec: 1'b0, clr: 1'b0, addr: item.station_address, stamp: item.now_time};
    query_go = 1'b0;
    if (accept) begin
      unique case (afwd_op_t'(item.op))
        OP_RECORD: wr.rec   = 1'b1;
        OP_CLEAR:  wr.clr   = 1'b1;
        OP_QUERY:  query_go = 1'b1;
        default:   ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds  <= WIN_W'(10);
      flood_threshold <= THR_W'(20);
    end else if (cfg.valid && cfg.ready) begin
      unique case (afwd_cfg_idx_t'(cfg.index))
        CFG_WINDOW:    window_seconds  <= cfg.data[WIN_W-1:0];
        CFG_THRESHOLD: flood_threshold <= cfg.data[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  afwd_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .rd_en      (state == S_READ),
    .rd_idx     (rd_idx),
    .query_time (query_time),
    .window     (window_seconds),
    .item       (ring_item)
  );

  // token enters the row in the cycle after the last swept slot's item does
  assign tok_in = '{valid: tok_launch, addr: '0};

  afwd_chain #(
    .RING_DEPTH (RING_DEPTH)
  ) u_chain (
    .clk         (clk),
    .rst         (rst),
    .flush       (query_go),
    .item_in     (ring_item),
    .tok_in      (tok_in),
    .tok_cnt_in  ('0),
    .item_out    (chain_item_out),
    .tok_out     (tok_out),
    .tok_cnt_out (tok_cnt_out)
  );

  // threshold and saturation of the winner
  assign res_wide = CmpW'(res_count);
  assign qualify  = res_wide >= CmpW'(flood_threshold);
  assign res_sat  = (res_wide > CmpW'(COUNT_MAX)) ? COUNT_MAX : res_wide[COUNT_W-1:0];

  // query sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_idx       <= '0;
      last_d1      <= 1'b0;
      last_d2      <= 1'b0;
      tok_launch   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      last_d1    <= (state == S_READ) && (rd_idx == LastIdx);
      last_d2    <= last_d1;
      tok_launch <= last_d2;
      // the wait state loads the result register itself
      if (result.valid && result.ready && state != S_WAIT) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (query_go) begin
            query_time <= item.now_time;
            rd_idx     <= '0;
            state      <= S_READ;
          end
        end
        S_READ: begin
          rd_idx <= rd_idx + 1'b1;
          if (rd_idx == LastIdx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (tok_out.valid) begin
            res_count <= tok_cnt_out;
            res_addr  <= tok_out.addr;
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.best_count   <= qualify ? res_sat : '0;
            result.best_address <= qualify ? res_addr : '0;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // every in-window address finds a cell before the end of the row
  `AFWD_ASSERT_NOW(a_no_spill, clk, rst, 1'b1, !chain_item_out.valid)
  // the token only leaves the row while a query drains
  `AFWD_ASSERT_NOW(a_tok_in_drain, clk, rst, tok_out.valid, state == S_DRAIN)
  // a new result only comes out of the wait state
  `AFWD_ASSERT_NOW(a_result_from_wait, clk, rst, $rose(result.valid), $past(state == S_WAIT))
  // a query starts the sweep at slot zero
  `AFWD_ASSERT_NEXT(a_query_starts, clk, rst, query_go, state == S_READ && rd_idx == '0)

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the auth flood window detector
// depends on afwd_pkg, the afwd channel interfaces and auth_flood_window_detector
`timescale 1ns / 1ps

module testbench;
  import afwd_pkg::*;

  localparam int RING_DEPTH    = 512;
  localparam int QUERY_LATENCY = 2 * RING_DEPTH + 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 3000;
  localparam int CYCLE_LIMIT   = 5_000_000;

  // codes outside the package enums
  localparam logic [OP_W-1:0]      OP_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_ONE  = 48'h0000_0000_0001;
  localparam logic [ADDR_W-1:0] ADDR_ALT  = 48'hAAAA_5555_AAAA;
  localparam logic [ADDR_W-1:0] ADDR_NONE = 48'h0;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [ADDR_W-1:0]  who;
  } flood_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  // code is an opcode for items, a register index for register rows
  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         code;
    logic [ADDR_W-1:0]  value;
    logic [TIME_W-1:0]  stamp;
    bit                 typed;
    logic [COUNT_W-1:0] cnt;
    logic [ADDR_W-1:0]  who;
  } plan_row_t;

  // directed rows; typed rows carry their own expected report
  localparam int PLAN_ROWS = 28;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // empty ring after reset
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd100,        1'b1, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_RECORD, ADDR_ONES, 32'hFFFF_FFFF,  1'b0, 10'd0, ADDR_NONE},
    // zero stamp reads as empty
    '{ROW_ITEM, OP_RECORD, ADDR_NONE, 32'd0,          1'b0, 10'd0, ADDR_NONE},
    // single hit under the reset threshold
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'hFFFF_FFFF,  1'b1, 10'd0, ADDR_NONE},
    '{ROW_REG,  CFG_THRESHOLD, 48'd0, 32'd0,          1'b0, 10'd0, ADDR_NONE},
    // threshold zero lets a single hit through
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'hFFFF_FFFF,  1'b1, 10'd1, ADDR_ONES},
    // stamp later than now still counts
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd0,          1'b1, 10'd1, ADDR_ONES},
    '{ROW_REG,  CFG_WINDOW, 48'd0, 32'd0,             1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_RECORD, ADDR_ONE,  32'd50,         1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_RECORD, ADDR_ONE,  32'd50,         1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_RECORD, ADDR_ALT,  32'd50,         1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd50,         1'b0, 10'd0, ADDR_NONE},
    // one second past a zero window
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd51,         1'b0, 10'd0, ADDR_NONE},
    // tie, lower first slot wins
    '{ROW_ITEM, OP_RECORD, ADDR_ALT,  32'd50,         1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd50,         1'b0, 10'd0, ADDR_NONE},
    // unused opcode and register indexes are ignored
    '{ROW_ITEM, OP_SPARE,  ADDR_ALT,  32'd50,         1'b0, 10'd0, ADDR_NONE},
    '{ROW_REG,  CFG_SPARE_LO, 48'hFFFF, 32'd0,        1'b0, 10'd0, ADDR_NONE},
    '{ROW_REG,  CFG_SPARE_HI, 48'hFFFF, 32'd0,        1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd50,         1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_CLEAR,  ADDR_ONES, 32'hFFFF_FFFF,  1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd50,         1'b1, 10'd0, ADDR_NONE},
    '{ROW_REG,  CFG_WINDOW, 48'hFFFF, 32'd0,          1'b0, 10'd0, ADDR_NONE},
    // threshold data masks down to 1023
    '{ROW_REG,  CFG_THRESHOLD, 48'hFFFF, 32'd0,       1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_RECORD, ADDR_ONE,  32'd1,          1'b0, 10'd0, ADDR_NONE},
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd65536,      1'b1, 10'd0, ADDR_NONE},
    '{ROW_REG,  CFG_THRESHOLD, 48'd1, 32'd0,          1'b0, 10'd0, ADDR_NONE},
    // age exactly at the widest window, then one past it
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd65536,      1'b1, 10'd1, ADDR_ONE},
    '{ROW_ITEM, OP_QUERY,  ADDR_NONE, 32'd65537,      1'b1, 10'd0, ADDR_NONE}
  };

  logic clk;
  logic rst;

  afwd_item_if   item_bus ();
  afwd_result_if flood_bus ();
  afwd_cfg_if    cfg_bus ();

  auth_flood_window_detector #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (flood_bus),
    .cfg    (cfg_bus)
  );

  // shadow ring and registers
  logic [ADDR_W-1:0] ring_addr  [RING_DEPTH];
  logic [TIME_W-1:0] ring_stamp [RING_DEPTH];
  int unsigned       ring_wr;
  logic [WIN_W-1:0]  win_cfg;
  logic [THR_W-1:0]  thr_cfg;

  flood_t pending_floods [$];

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned queries_sent;
  int unsigned reports_seen;
  int unsigned reports_hit;
  int unsigned reg_writes;
  bit          hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // frequency count over the live slots, ties go to the lowest first slot
  function automatic flood_t flood_lookup(input logic [TIME_W-1:0] now);
    int          tally    [logic [ADDR_W-1:0]];
    int          first_at [logic [ADDR_W-1:0]];
    bit          live     [RING_DEPTH];
    longint      age;
    longint      lim;
    longint      now_l;
    longint      stamp_l;
    int          best;
    logic [ADDR_W-1:0] best_who;
    logic [ADDR_W-1:0] a;
    flood_t      res;
    lim   = win_cfg;
    now_l = now;
    for (int i = 0; i < RING_DEPTH; i++) begin
      stamp_l = ring_stamp[i];
      age     = now_l - stamp_l;
      live[i] = (ring_stamp[i] != '0) && (age <= lim);
      if (live[i]) begin
        a = ring_addr[i];
        if (!tally.exists(a)) begin
          tally[a]    = 0;
          first_at[a] = i;
        end
        tally[a]++;
      end
    end
    best     = 0;
    best_who = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      a = ring_addr[i];
      if (live[i] && first_at[a] == i) begin
        if (tally[a] >= int'(thr_cfg) && tally[a] > best) begin
          best     = tally[a];
          best_who = a;
        end
      end
    end
    res.cnt = (best > int'(COUNT_MAX)) ? COUNT_MAX : best[COUNT_W-1:0];
    res.who = best_who;
    return res;
  endfunction

  // apply an accepted item to the shadow ring, queue the report of a query
  function automatic void track_item(input logic [OP_W-1:0] op,
                                     input logic [ADDR_W-1:0] addr,
                                     input logic [TIME_W-1:0] stamp,
                                     input bit typed, input flood_t typed_val);
    items_sent++;
    case (op)
      OP_RECORD: begin
        ring_addr[ring_wr]  = addr;
        ring_stamp[ring_wr] = stamp;
        ring_wr = (ring_wr + 1 >= RING_DEPTH) ? 0 : ring_wr + 1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          ring_addr[i]  = '0;
          ring_stamp[i] = '0;
        end
        ring_wr = 0;
      end
      OP_QUERY: begin
        queries_sent++;
        pending_floods.push_back(typed ? typed_val : flood_lookup(stamp));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // offer one transaction and hold it until taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [TIME_W-1:0] stamp, input bit typed,
                           input flood_t typed_val, input int unsigned gap);
    item_bus.valid           <= 1'b1;
    item_bus.op              <= op;
    item_bus.station_address <= addr;
    item_bus.now_time        <= stamp;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    track_item(op, addr, stamp, typed, typed_val);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain every outstanding report before touching registers
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_floods.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_WINDOW:    win_cfg = val;
      CFG_THRESHOLD: thr_cfg = val[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // random traffic around a drifting clock: bursts on a small set of stations
  task automatic run_traffic(input logic [CFG_DATA_W-1:0] win,
                             input logic [CFG_DATA_W-1:0] thr,
                             input int pool_n, input int query_pct,
                             input int n_items, input logic [TIME_W-1:0] t0,
                             input bit clean, input bit squeeze);
    logic [ADDR_W-1:0] pool [8];
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] tclk;
    logic [TIME_W-1:0] stamp;
    flood_t            no_val;
    int unsigned       r;
    int unsigned       sr;
    int                n;
    no_val = '0;
    wait_idle();
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_THRESHOLD, thr);
    if (clean) send_item(OP_CLEAR, rand_addr(), $urandom, 1'b0, no_val, 0);
    foreach (pool[k]) pool[k] = rand_addr();
    tclk = t0;
    if (squeeze) hold_request = 1'b1;
    n = 0;
    while (n < n_items) begin
      r = $urandom_range(0, 99);
      if (r < query_pct) begin
        stamp = (!clean && $urandom_range(0, 9) == 0) ? $urandom
                                                       : tclk + $urandom_range(0, 4);
        send_item(OP_QUERY, rand_addr(), stamp, 1'b0, no_val, pick_gap(clean));
        n++;
      end else if (!clean && r < query_pct + 2) begin
        send_item(OP_CLEAR, rand_addr(), $urandom, 1'b0, no_val, pick_gap(clean));
        n++;
      end else if (!clean && r < query_pct + 4) begin
        send_item(OP_SPARE, rand_addr(), $urandom, 1'b0, no_val, pick_gap(clean));
      end else begin
        tclk = tclk + $urandom_range(0, 2);
        addr = (clean || $urandom_range(0, 99) < 80) ? pool[$urandom_range(0, pool_n - 1)]
                                                      : rand_addr();
        sr = $urandom_range(0, 19);
        if (clean)        stamp = tclk;
        else if (sr == 0) stamp = '0;
        else if (sr < 3)  stamp = $urandom;
        else if (sr == 3) stamp = tclk + 2;
        else              stamp = tclk - $urandom_range(0, 3);
        send_item(OP_RECORD, addr, stamp, 1'b0, no_val, pick_gap(clean));
        n++;
      end
    end
  endtask

  // result side: random stalls, free-running stretches, one long hold-off on request
  initial begin : report_sink
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned r;
    stall_left = 0;
    free_left  = 0;
    flood_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
        free_left    = 0;
      end
      if (stall_left > 0) begin
        flood_bus.ready <= 1'b0;
        stall_left--;
      end else if (free_left > 0) begin
        flood_bus.ready <= 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          flood_bus.ready <= 1'b1;
        end else if (r < 75) begin
          flood_bus.ready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (r < 80) begin
          flood_bus.ready <= 1'b0;
          stall_left = $urandom_range(20, 80);
        end else begin
          flood_bus.ready <= 1'b1;
          free_left = $urandom_range(200, 2000);
        end
      end
    end
  end

  // compare each report transaction with the oldest expectation
  always @(posedge clk) begin : report_check
    flood_t want;
    if (!rst && flood_bus.valid && flood_bus.ready) begin
      reports_seen++;
      if (flood_bus.best_count != '0) reports_hit++;
      if (pending_floods.size() == 0) begin
        $error("unexpected report: best_count %0d best_address %h",
               flood_bus.best_count, flood_bus.best_address);
        errors++;
      end else begin
        want = pending_floods.pop_front();
        if (flood_bus.best_count !== want.cnt) begin
          $error("best_count: expected %0d, actual %0d", want.cnt, flood_bus.best_count);
          errors++;
        end
        if (flood_bus.best_address !== want.who) begin
          $error("best_address: expected %h, actual %h", want.who, flood_bus.best_address);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // reset, directed table, random traffic, drain
  initial begin : stimulus
    plan_row_t row;
    flood_t    typed_val;
    errors       = 0;
    cycle_count  = 0;
    items_sent   = 0;
    queries_sent = 0;
    reports_seen = 0;
    reports_hit  = 0;
    reg_writes   = 0;
    hold_request = 1'b0;
    ring_wr      = 0;
    win_cfg      = 16'd10;
    thr_cfg      = 10'd20;
    foreach (ring_addr[i]) begin
      ring_addr[i]  = '0;
      ring_stamp[i] = '0;
    end
    rst = 1'b1;
    item_bus.valid           <= 1'b0;
    item_bus.op              <= OP_RECORD;
    item_bus.station_address <= '0;
    item_bus.now_time        <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_WINDOW;
    cfg_bus.data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_PLAN[k]) begin
      row = DIRECTED_PLAN[k];
      if (row.kind == ROW_REG) begin
        wait_idle();
        write_reg(row.code, row.value[CFG_DATA_W-1:0]);
      end else begin
        typed_val.cnt = row.cnt;
        typed_val.who = row.who;
        send_item(row.code, row.value, row.stamp, row.typed, typed_val, pick_gap(1'b0));
      end
    end

    run_traffic(16'd10, 16'd2, 3, 15, 120, $urandom, 1'b0, 1'b0);
    // clock close to zero
    run_traffic(16'd0, 16'd1, 2, 15, 100, 32'd3, 1'b0, 1'b0);
    // widest window while the report side holds off
    run_traffic(16'hFFFF, 16'd0, 6, 15, 120, $urandom, 1'b0, 1'b1);
    // one station fills the whole ring
    run_traffic(16'hFFFF, 16'd512, 1, 3, 560, 32'h0100_0000, 1'b1, 1'b0);
    run_traffic(16'($urandom_range(1, 200)), 16'($urandom_range(1, 40)), 4, 15, 150,
                $urandom, 1'b0, 1'b0);
    // clock wraps through zero
    run_traffic(16'd30, 16'd5, 3, 15, 120, 32'hFFFF_FF80, 1'b0, 1'b0);

    item_bus.valid <= 1'b0;
    while (pending_floods.size() != 0) @(posedge clk);
    repeat (QUERY_LATENCY) @(posedge clk);

    $display("tb: %0d item transactions, %0d queries, %0d register writes",
             items_sent, queries_sent, reg_writes);
    $display("tb: %0d flood reports checked, %0d naming a station, %0d mismatches",
             reports_seen, reports_hit, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
